>>> design/cls_pkg.sv
// Shared types and constants for the compacting list store.
// Used by cls_cell and compacting_list_store; depends on nothing.
`default_nettype none

package cls_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int MAX_CELLS     = 16;
  localparam int DATA_W        = 32;
  localparam int IDX_W         = 4;
  localparam int CNT_W         = IDX_W + 1;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int S_TDATA_W     = 40;
  localparam int M_TDATA_W     = 40;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_WRAP
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> design/compacting_list_store.sv
// Top level of the compacting list store: control, fill count, result
// register and the chain of cls_cell storage cells. Depends on cls_pkg.
//
// Usage:
//   Input words arrive on the s_ channel: op, position and new_value.
//   Results leave on the m_ channel: status, read_value, read_index, with
//   tlast marking the final result of each input word.
//   Append, update and delete give a single result, which is in the
//   output register on the cycle after acceptance, and the next word can be
//   taken in that same cycle if the receiver drains the register.
//   Read all on a non-empty list first enters the read state, then gives one
//   result per cycle for N entries while the receiver is ready. The cells rotate
//   one place toward cell 0 per result, so after N steps the list is back in
//   its original order; s_tready_o stays low meanwhile.
//   Capacity is min(DEPTH, 16) entries, one cell each.
//   Reset empties the list (fill count zero) and drops any pending result;
//   cell contents are not cleared and are never shown before being written.
//   When the receiver stalls, the result register holds, the cells stop
//   rotating and no new input word is accepted.
`default_nettype none

module compacting_list_store #(
  parameter int DEPTH = cls_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // [1:0] op, [5:2] position, [37:6] new_value, [39:38] zero
  input  logic [cls_pkg::S_TDATA_W-1:0] s_tdata_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // [1:0] status, [33:2] read_value, [37:34] read_index, [39:38] zero
  output logic [cls_pkg::M_TDATA_W-1:0] m_tdata_o,
  output logic                          m_tlast_o
);

  localparam int CAP = (DEPTH < cls_pkg::MAX_CELLS) ? DEPTH : cls_pkg::MAX_CELLS;
  localparam int CW  = $clog2(CAP + 1);
  localparam logic [cls_pkg::CNT_W-1:0] CAP_CNT = cls_pkg::CNT_W'(CAP);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e                         state_q;
  logic                           out_valid_q;
  cls_pkg::status_e               status_q;
  logic [cls_pkg::DATA_W-1:0]     value_q;
  logic [cls_pkg::IDX_W-1:0]      index_q;
  logic                           last_q;
  logic [CW-1:0]                  count_q;
  logic [cls_pkg::IDX_W-1:0]      idx_q;

  cls_pkg::op_e                   in_op;
  logic [cls_pkg::IDX_W-1:0]      in_pos;
  logic [cls_pkg::DATA_W-1:0]     in_value;
  logic [cls_pkg::CNT_W-1:0]      cnt;
  logic [cls_pkg::CNT_W-1:0]      pos_ext;
  logic                           out_free;
  logic                           accept;
  logic                           emit;
  logic                           emit_last;
  logic                           is_empty;
  logic                           pos_bad;
  logic                           app_ok;
  logic                           upd_ok;
  logic                           del_ok;

  logic [cls_pkg::DATA_W-1:0]     cell_val [CAP];
  cls_pkg::cell_ctl_t             cell_ctl [CAP];

  assign in_op    = cls_pkg::op_e'(s_tdata_i[1:0]);
  assign in_pos   = s_tdata_i[5:2];
  assign in_value = s_tdata_i[37:6];

  assign cnt       = cls_pkg::CNT_W'(count_q);
  assign pos_ext   = {1'b0, in_pos};
  assign out_free  = !out_valid_q || m_tready_i;
  assign s_tready_o = (state_q == S_IDLE) && out_free;
  assign accept    = s_tvalid_i && s_tready_o;
  assign emit      = (state_q == S_READ) && out_free;
  assign emit_last = (cls_pkg::CNT_W'(idx_q) + cls_pkg::CNT_W'(1)) == cnt;
  assign is_empty  = (cnt == '0);
  assign pos_bad   = (pos_ext >= cnt);
  assign app_ok    = accept && (in_op == cls_pkg::OP_APPEND) && (cnt < CAP_CNT);
  assign upd_ok    = accept && (in_op == cls_pkg::OP_UPDATE) && !is_empty && !pos_bad;
  assign del_ok    = accept && (in_op == cls_pkg::OP_DELETE) && !is_empty && !pos_bad;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    localparam logic [cls_pkg::CNT_W-1:0] CELL_IDX = cls_pkg::CNT_W'(i);
    localparam logic [cls_pkg::CNT_W-1:0] CELL_NXT = cls_pkg::CNT_W'(i + 1);

    logic [cls_pkg::DATA_W-1:0] next_val;

    if (i < CAP - 1) begin : g_mid
      assign next_val = cell_val[i+1];
    end else begin : g_end
      assign next_val = cell_val[0];
    end

    always_comb begin
      cell_ctl[i].mode = cls_pkg::CELL_HOLD;
      if (app_ok && (CELL_IDX == cnt)) begin
        cell_ctl[i].mode = cls_pkg::CELL_LOAD;
      end else if (upd_ok && (CELL_IDX == pos_ext)) begin
        cell_ctl[i].mode = cls_pkg::CELL_LOAD;
      end else if (del_ok && (CELL_IDX >= pos_ext) && (CELL_NXT < cnt)) begin
        cell_ctl[i].mode = cls_pkg::CELL_SHIFT;
      end else if (emit) begin
        if (CELL_NXT < cnt) begin
          cell_ctl[i].mode = cls_pkg::CELL_SHIFT;
        end else if (CELL_NXT == cnt) begin
          cell_ctl[i].mode = cls_pkg::CELL_WRAP;
        end
      end
    end

    cls_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl[i]),
      .new_value_i (in_value),
      .next_value_i(next_val),
      .head_value_i(cell_val[0]),
      .value_o     (cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= cls_pkg::ST_OK;
      value_q     <= '0;
      index_q     <= '0;
      last_q      <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
      value_q     <= '0;
      index_q     <= '0;
      last_q      <= 1'b1;
      status_q    <= cls_pkg::ST_OK;
      unique case (in_op)
        cls_pkg::OP_APPEND: begin
          if (cnt >= CAP_CNT) begin
            status_q <= cls_pkg::ST_FULL;
          end else begin
            count_q <= CW'(cnt + cls_pkg::CNT_W'(1));
          end
        end
        cls_pkg::OP_READ: begin
          if (is_empty) begin
            status_q <= cls_pkg::ST_EMPTY;
          end else begin
            out_valid_q <= 1'b0;
            idx_q       <= '0;
            state_q     <= S_READ;
          end
        end
        cls_pkg::OP_UPDATE: begin
          if (is_empty) begin
            status_q <= cls_pkg::ST_EMPTY;
          end else if (pos_bad) begin
            status_q <= cls_pkg::ST_BADIDX;
          end
        end
        default: begin
          if (is_empty) begin
            status_q <= cls_pkg::ST_EMPTY;
          end else if (pos_bad) begin
            status_q <= cls_pkg::ST_BADIDX;
          end else begin
            count_q <= CW'(cnt - cls_pkg::CNT_W'(1));
          end
        end
      endcase
    end else if (emit) begin
      out_valid_q <= 1'b1;
      status_q    <= cls_pkg::ST_OK;
      value_q     <= cell_val[0];
      index_q     <= idx_q;
      last_q      <= emit_last;
      idx_q       <= idx_q + cls_pkg::IDX_W'(1);
      if (emit_last) begin
        state_q <= S_IDLE;
      end
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tlast_o  = last_q;
  assign m_tdata_o  = {2'b00, index_q, value_q, status_q};

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= CAP_CNT)
    else $error("fill count above capacity");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (!is_empty && (cls_pkg::CNT_W'(idx_q) < cnt)))
    else $error("read walk outside the list");

  a_count_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("fill count changed without an input word");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != cls_pkg::ST_OK)) |-> last_q)
    else $error("error status without last mark");

  a_no_accept_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !s_tready_o)
    else $error("input taken during read walk");

endmodule

`default_nettype wire

>>> design/cls_cell.sv
// One storage cell of the list chain: holds, loads a new word, takes its
// upper neighbor, or takes the head word. Depends on cls_pkg.
`default_nettype none

module cls_cell (
  input  logic                       clk_i,
  input  cls_pkg::cell_ctl_t         ctl_i,
  input  logic [cls_pkg::DATA_W-1:0] new_value_i,
  input  logic [cls_pkg::DATA_W-1:0] next_value_i,
  input  logic [cls_pkg::DATA_W-1:0] head_value_i,
  output logic [cls_pkg::DATA_W-1:0] value_o
);

  logic [cls_pkg::DATA_W-1:0] value_q;
  logic [cls_pkg::DATA_W-1:0] value_d;

  always_comb begin
    unique case (ctl_i.mode)
      cls_pkg::CELL_LOAD:  value_d = new_value_i;
      cls_pkg::CELL_SHIFT: value_d = next_value_i;
      cls_pkg::CELL_WRAP:  value_d = head_value_i;
      default:             value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

>>> tb/compacting_list_store_tb.sv
// Self-checking testbench for compacting_list_store: a directed table, then random
// append, read, update and delete words, checked against a shadow copy of the list.
// Depends on cls_pkg and compacting_list_store.
`default_nettype none

module compacting_list_store_tb;
  import cls_pkg::*;

  localparam int CAPACITY    = (DEPTH_DEFAULT < MAX_CELLS) ? DEPTH_DEFAULT : MAX_CELLS;
  localparam int RAND_WORDS  = 450;
  localparam int LONG_HOLD   = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NDIR        = 17;

  typedef struct {
    status_e     status;
    logic [31:0] value;
    logic [3:0]  index;
    logic        last;
  } result_t;

  typedef struct {
    op_e         op;
    logic [3:0]  pos;
    logic [31:0] val;
    int          rep;
    bit          fixed;
    status_e     status;
  } dir_step_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 s_tvalid_i = 1'b0;
  logic                 s_tready_o;
  logic [S_TDATA_W-1:0] s_tdata_i  = '0;
  logic                 m_tvalid_o;
  logic                 m_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata_o;
  logic                 m_tlast_o;

  logic [31:0] shadow_cells [MAX_CELLS];
  int          shadow_count = 0;
  result_t     pending_results [$];
  dir_step_t   plan [NDIR];

  int errors        = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int cycle_count   = 0;
  int holds_asked   = 0;
  int holds_served  = 0;
  int burst_left    = 0;
  int status_hits [4] = '{0, 0, 0, 0};

  compacting_list_store #(.DEPTH(DEPTH_DEFAULT)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic int list_apply(input op_e op, input logic [3:0] pos,
                                    input logic [31:0] val, output result_t outs [MAX_CELLS]);
    int n;
    int k;
    n = shadow_count;
    outs[0] = '{ST_OK, 32'd0, 4'd0, 1'b1};
    case (op)
      OP_APPEND: begin
        if (n >= CAPACITY) begin
          outs[0].status = ST_FULL;
        end else begin
          shadow_cells[n] = val;
          shadow_count = n + 1;
        end
      end
      OP_READ: begin
        if (n == 0) begin
          outs[0].status = ST_EMPTY;
        end else begin
          for (k = 0; k < n; k++)
            outs[k] = '{ST_OK, shadow_cells[k], k[3:0], (k == n - 1)};
          return n;
        end
      end
      default: begin
        if (n == 0) begin
          outs[0].status = ST_EMPTY;
        end else if (int'(pos) >= n) begin
          outs[0].status = ST_BADIDX;
        end else if (op == OP_UPDATE) begin
          shadow_cells[pos] = val;
        end else begin
          for (k = int'(pos); k + 1 < n; k++)
            shadow_cells[k] = shadow_cells[k + 1];
          shadow_count = n - 1;
        end
      end
    endcase
    return 1;
  endfunction

  // hold the word until it is taken, then queue what it should produce
  task automatic offer(input op_e op, input logic [3:0] pos, input logic [31:0] val,
                       input bit fixed, input status_e status);
    result_t outs [MAX_CELLS];
    int      cnt;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {2'b00, val, pos, op};
    do @(posedge clk_i); while (!s_tready_o);
    words_sent++;
    cnt = list_apply(op, pos, val, outs);
    if (fixed)
      pending_results.push_back('{status, 32'd0, 4'd0, 1'b1});
    else
      for (int k = 0; k < cnt; k++) pending_results.push_back(outs[k]);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin : receiver_pace
    int hold_left;
    int mode_left;
    int mode;
    int phase;
    hold_left = 0;
    mode_left = 0;
    mode      = 0;
    phase     = 0;
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready_i <= 1'b0;
      end else begin
        case (mode)
          0:       m_tready_i <= 1'b1;
          1:       m_tready_i <= ($urandom_range(0, 9) < 7);
          2:       m_tready_i <= ($urandom_range(0, 9) < 3);
          default: m_tready_i <= (phase % 4 != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = '{status_e'(m_tdata_o[1:0]), m_tdata_o[33:2], m_tdata_o[37:34], m_tlast_o};
      results_seen++;
      status_hits[m_tdata_o[1:0]]++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word status=%0d value=%h index=%0d last=%b", $time,
                 got.status, got.value, got.index, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.value !== want.value ||
            got.index !== want.index || got.last !== want.last ||
            m_tdata_o[39:38] !== 2'b00) begin
          errors++;
          $display("%0t: mismatch expected status=%0d value=%h index=%0d last=%b", $time,
                   want.status, want.value, want.index, want.last);
          $display("%0t:          actual   status=%0d value=%h index=%0d last=%b pad=%b",
                   $time, got.status, got.value, got.index, got.last, m_tdata_o[39:38]);
        end
      end
    end
  end

  initial begin : stimulus
    op_e        op;
    logic [3:0] pos;
    int         grow_left;
    bit         grow;

    plan[0]  = '{OP_READ,   4'd0,  32'h0000_0000, 1,  1'b1, ST_EMPTY};
    plan[1]  = '{OP_UPDATE, 4'd0,  32'h1234_5678, 1,  1'b1, ST_EMPTY};
    plan[2]  = '{OP_DELETE, 4'd15, 32'h0000_0000, 1,  1'b1, ST_EMPTY};
    plan[3]  = '{OP_APPEND, 4'd0,  32'h7FFF_FFFF, 1,  1'b1, ST_OK};
    plan[4]  = '{OP_APPEND, 4'd15, 32'h8000_0000, 1,  1'b1, ST_OK};
    plan[5]  = '{OP_APPEND, 4'd0,  32'h0000_0000, 1,  1'b1, ST_OK};
    plan[6]  = '{OP_APPEND, 4'd0,  32'hFFFF_FFFF, 1,  1'b1, ST_OK};
    plan[7]  = '{OP_READ,   4'd0,  32'h0000_0000, 1,  1'b0, ST_OK};
    plan[8]  = '{OP_UPDATE, 4'd4,  32'hDEAD_BEEF, 1,  1'b1, ST_BADIDX};
    plan[9]  = '{OP_UPDATE, 4'd0,  32'h5555_5555, 1,  1'b1, ST_OK};
    plan[10] = '{OP_DELETE, 4'd15, 32'h0000_0000, 1,  1'b1, ST_BADIDX};
    plan[11] = '{OP_APPEND, 4'd0,  32'hA5A5_0000, 12, 1'b1, ST_OK};
    plan[12] = '{OP_APPEND, 4'd0,  32'hAAAA_AAAA, 1,  1'b1, ST_FULL};
    plan[13] = '{OP_READ,   4'd0,  32'h0000_0000, 1,  1'b0, ST_OK};
    plan[14] = '{OP_DELETE, 4'd0,  32'h0000_0000, 1,  1'b1, ST_OK};
    plan[15] = '{OP_DELETE, 4'd14, 32'h0000_0000, 1,  1'b1, ST_OK};
    plan[16] = '{OP_READ,   4'd0,  32'h0000_0000, 1,  1'b0, ST_OK};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r])
      for (int k = 0; k < plan[r].rep; k++) begin
        offer(plan[r].op, plan[r].pos, plan[r].val + 32'h0101_0101 * k, plan[r].fixed,
              plan[r].status);
        pace();
      end
    drain();

    grow      = 1'b1;
    grow_left = $urandom_range(20, 50);
    for (int w = 0; w < RAND_WORDS; w++) begin
      if (grow_left == 0) begin
        grow      = ~grow;
        grow_left = $urandom_range(20, 50);
      end
      grow_left--;
      case ($urandom_range(0, 19))
        0, 1:                       op = OP_READ;
        2, 3, 4:                    op = OP_UPDATE;
        5, 6, 7, 8, 9, 10, 11, 12:  op = grow ? OP_APPEND : OP_DELETE;
        default:                    op = grow ? OP_APPEND : OP_DELETE;
      endcase
      if ($urandom_range(0, 9) == 0) op = op_e'($urandom_range(0, 3));
      if (shadow_count > 0 && $urandom_range(0, 9) < 8)
        pos = 4'($urandom_range(0, shadow_count - 1));
      else
        pos = 4'($urandom_range(0, 15));
      // stall the output for a long stretch while words keep coming
      if (w == 120) begin
        holds_asked++;
        burst_left = 20;
      end
      if (w == 200 || w == 350) drain();
      offer(op, pos, pick_value(), 1'b0, ST_OK);
      pace();
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("words in: %0d, results out: %0d, list depth %0d", words_sent, results_seen,
             CAPACITY);
    $display("results by status ok/full/empty/bad index: %0d/%0d/%0d/%0d", status_hits[0],
             status_hits[1], status_hits[2], status_hits[3]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/cls_pkg.sv
design/cls_cell.sv
design/compacting_list_store.sv
tb/compacting_list_store_tb.sv
